// ----- rtl/greedy_point_cover_counter_defines.svh -----
// ----------------------------------------------------------------------------
// greedy point cover counter assertion macros
// concurrent assertion shorthands, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef GREEDY_POINT_COVER_COUNTER_DEFINES_SVH
`define GREEDY_POINT_COVER_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define GPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define GPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`else

`define GPC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/gpc_pkg.sv -----
// ----------------------------------------------------------------------------
// gpc_pkg
// shared constants and types of the greedy point cover counter
// ----------------------------------------------------------------------------
`default_nettype none

package gpc_pkg;

	localparam int MAX_POINTS = 64;
	localparam int POS_WIDTH  = 16;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int END_W      = POS_WIDTH + 2;
	localparam int LEN_W      = 16;

	typedef logic [POS_WIDTH-1:0] pos_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [END_W-1:0]     end_t;

	// control of the cell chain
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

	// control of the sweep unit
	typedef struct packed {
		logic clear;
		logic step;
	} sweep_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_SWEEP = 2'b10
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/gpc_cell.sv -----
// ----------------------------------------------------------------------------
// gpc_cell
// one slot of the insertion sort chain
// ----------------------------------------------------------------------------
`default_nettype none

module gpc_cell (
	input  wire logic               clk,
	input  wire gpc_pkg::cell_ctl_t ctl,
	input  wire gpc_pkg::pos_t      pos,
	input  wire logic               occupied,
	input  wire gpc_pkg::pos_t      prev_val,
	input  wire logic               prev_gt,
	input  wire gpc_pkg::pos_t      next_val,
	output gpc_pkg::pos_t           val,
	output logic                    gt
);

	gpc_pkg::pos_t val_q;

	// empty slots count as above every point
	assign gt  = !occupied || (val_q > pos);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (gt) begin
				val_q <= prev_gt ? prev_val : pos;
			end
		end else if (ctl.shift) begin
			val_q <= next_val;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/gpc_sweep.sv -----
// ----------------------------------------------------------------------------
// gpc_sweep
// greedy cover step over one sorted point per cycle while step is set
// ----------------------------------------------------------------------------
`default_nettype none

module gpc_sweep (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gpc_pkg::sweep_ctl_t           ctl,
	input  wire gpc_pkg::pos_t                 point,
	input  wire logic [gpc_pkg::LEN_W-1:0]     patch_length,
	output gpc_pkg::cnt_t                      next_patches
);

	gpc_pkg::end_t cover_end_q;
	gpc_pkg::cnt_t patches_used_q;

	gpc_pkg::end_t        p;
	gpc_pkg::end_t        pm1;
	gpc_pkg::end_t        base;
	logic [gpc_pkg::END_W:0] sum;
	logic                 covered;

	always_comb begin
		p       = gpc_pkg::END_W'({point, 1'b0});
		pm1     = p - gpc_pkg::END_W'(1);
		covered = cover_end_q > p;
		base    = ((p != '0) && (pm1 > cover_end_q)) ? pm1 : cover_end_q;
		sum     = {1'b0, base} + (gpc_pkg::END_W + 1)'({patch_length, 1'b0});
	end

	assign next_patches = covered ? patches_used_q : patches_used_q + gpc_pkg::CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cover_end_q    <= '0;
			patches_used_q <= '0;
		end else if (ctl.clear) begin
			cover_end_q    <= '0;
			patches_used_q <= '0;
		end else if (ctl.step && !covered) begin
			cover_end_q    <= sum[gpc_pkg::END_W-1:0];
			patches_used_q <= next_patches;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/greedy_point_cover_counter.sv -----
// ----------------------------------------------------------------------------
// greedy_point_cover_counter
// sorts a set of points in a cell chain and counts the fewest patches
// ----------------------------------------------------------------------------
//
// channel   signals                             direction  transfer
// config    cfg_valid cfg_ready cfg_data        in         cfg_valid && cfg_ready
// points    start busy leak_position last_point in         start && !busy
// result    done patch_count                    out        done (one cycle)
//
// a point without the last flag is inserted into the sorted chain of
// MAX_POINTS cells at once; a point with the last flag is stored as well
// and busy then holds while the chain shifts every stored point into the
// sweep unit, one point a cycle; the count shows on done in the cycle after
// the final sweep step
// reset clears the fill count, the sweep registers and sets patch_length to 1
// the result side cannot stall; a new point may be taken while done is high
// points beyond the chain depth are dropped, a last flag on them still sweeps
// ----------------------------------------------------------------------------
`default_nettype none

`include "greedy_point_cover_counter_defines.svh"

module greedy_point_cover_counter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [gpc_pkg::LEN_W-1:0] cfg_data,
	// points
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] leak_position,
	input  wire logic        last_point,
	// result
	output logic             done,
	output logic [6:0]       patch_count
);

	localparam int N = gpc_pkg::MAX_POINTS;

	gpc_pkg::state_t   state_q;
	gpc_pkg::cnt_t     count_q;      // points loaded
	gpc_pkg::cnt_t     rem_q;        // sweep steps left
	logic [gpc_pkg::LEN_W-1:0] patch_length_q;
	logic              done_q;
	gpc_pkg::cnt_t     patch_count_q;

	gpc_pkg::pos_t     pos;
	gpc_pkg::pos_t     cell_val [N];
	logic              cell_gt  [N];
	gpc_pkg::cell_ctl_t cell_ctl;
	gpc_pkg::sweep_ctl_t sweep_ctl;
	gpc_pkg::cnt_t     next_patches;
	gpc_pkg::cnt_t     loaded_next;
	logic              accept;
	logic              full;
	logic              last_step;

	// config register is always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patch_length_q <= gpc_pkg::LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			patch_length_q <= cfg_data;
		end
	end

	// input transfer and chain control
	assign busy        = (state_q == gpc_pkg::ST_SWEEP);
	assign accept      = start && !busy;
	assign full        = (count_q == gpc_pkg::CNT_W'(N));
	assign pos         = leak_position[gpc_pkg::POS_WIDTH-1:0];
	assign loaded_next = full ? count_q : count_q + gpc_pkg::CNT_W'(1);
	assign last_step   = busy && (rem_q == gpc_pkg::CNT_W'(1));

	assign cell_ctl.insert  = accept && !full;
	assign cell_ctl.shift   = busy;
	assign sweep_ctl.clear  = accept && last_point;
	assign sweep_ctl.step   = busy;

	// the cell chain: cell 0 feeds the sweep unit while busy
	for (genvar i = 0; i < N; i++) begin : g_cell
		localparam gpc_pkg::cnt_t IDX = gpc_pkg::CNT_W'(i);
		gpc_pkg::pos_t prev_val;
		logic          prev_gt;
		gpc_pkg::pos_t next_val;

		if (i == 0) begin : g_head
			assign prev_val = pos;
			assign prev_gt  = 1'b0;
		end else begin : g_body
			assign prev_val = cell_val[i-1];
			assign prev_gt  = cell_gt[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign next_val = cell_val[i];
		end else begin : g_mid
			assign next_val = cell_val[i+1];
		end

		gpc_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.pos      (pos),
			.occupied (IDX < count_q),
			.prev_val (prev_val),
			.prev_gt  (prev_gt),
			.next_val (next_val),
			.val      (cell_val[i]),
			.gt       (cell_gt[i])
		);
	end

	gpc_sweep u_sweep (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (sweep_ctl),
		.point        (cell_val[0]),
		.patch_length (patch_length_q),
		.next_patches (next_patches)
	);

	// sequencer: load, then sweep the stored points
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gpc_pkg::ST_IDLE;
			count_q <= '0;
			rem_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				gpc_pkg::ST_IDLE: begin
					if (accept) begin
						if (last_point) begin
							count_q <= '0;
							rem_q   <= loaded_next;
							state_q <= gpc_pkg::ST_SWEEP;
						end else begin
							count_q <= loaded_next;
						end
					end
				end
				gpc_pkg::ST_SWEEP: begin
					rem_q <= rem_q - gpc_pkg::CNT_W'(1);
					if (rem_q == gpc_pkg::CNT_W'(1)) begin
						done_q  <= 1'b1;
						state_q <= gpc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= gpc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// result register, loaded on the final sweep step
	always_ff @(posedge clk) begin
		if (last_step) begin
			patch_count_q <= next_patches;
		end
	end

	assign done        = done_q;
	assign patch_count = 7'(patch_count_q);

	// final sweep step is followed by the result strobe
	`GPC_ASSERT_NEXT(a_done_after_sweep, clk, arst_n, last_step, done && !busy)
	// a result appears only straight after a sweep
	`GPC_ASSERT_SAME(a_done_only_after, clk, arst_n, done, $past(busy))
	// the fill count is cleared for the whole sweep
	`GPC_ASSERT_SAME(a_empty_in_sweep, clk, arst_n, busy, count_q == '0 && rem_q != '0)
	// the fill count never passes the chain depth
	`GPC_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= gpc_pkg::CNT_W'(N))

endmodule

`default_nettype wire

// ----- test/greedy_point_cover_counter_test.sv -----
// ----------------------------------------------------------------------------
// greedy_point_cover_counter_test
// streams point sets into the cover counter under several patch lengths and
// checks every count against a sorted-set greedy sweep kept in the testbench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module greedy_point_cover_counter_test;

	import gpc_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 6;
	// covers the sweep of a full chain and the count that follows it
	localparam int DRAIN_CYCLES = MAX_POINTS + 16;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int POINT_GOAL   = 1450;

	// collects the points of the open set in ascending order and predicts the
	// patch count that each closing point should produce
	class cover_tally;
		pos_t             set_points[$];
		logic [LEN_W-1:0] patch_len;
		cnt_t             counts_due[$];
		int               mismatches;
		int               sets_closed;
		int               counts_seen;
		int               points_taken;
		int               points_dropped;

		function new();
			patch_len      = 16'd1;
			mismatches     = 0;
			sets_closed    = 0;
			counts_seen    = 0;
			points_taken   = 0;
			points_dropped = 0;
		endfunction

		// greedy sweep over the sorted set in doubled units
		function cnt_t count_patches();
			end_t reach;
			end_t span;
			end_t dbl;
			end_t base;
			int   used;
			reach = '0;
			span  = {{(END_W-LEN_W-1){1'b0}}, patch_len, 1'b0};
			used  = 0;
			foreach (set_points[i]) begin
				dbl = {1'b0, set_points[i], 1'b0};
				if (reach < dbl + end_t'(1)) begin
					base = reach;
					// a point at zero never lifts the base
					if (dbl != '0 && dbl - end_t'(1) > base)
						base = dbl - end_t'(1);
					reach = base + span;
					used++;
				end
			end
			return cnt_t'(used);
		endfunction

		// one accepted point transfer
		function void note_point(pos_t pos, logic last);
			int slot;
			points_taken++;
			if (set_points.size() < MAX_POINTS) begin
				slot = set_points.size();
				while (slot > 0 && set_points[slot-1] > pos)
					slot--;
				set_points.insert(slot, pos);
			end else begin
				// chain full, point is lost but its last flag still counts
				points_dropped++;
			end
			if (last) begin
				counts_due.push_back(count_patches());
				set_points.delete();
				sets_closed++;
			end
		endfunction

		// one result strobe
		function void check_count(cnt_t got);
			cnt_t want;
			counts_seen++;
			if (counts_due.size() == 0) begin
				$error("patch_count %0d arrived with no set closed", got);
				mismatches++;
			end else begin
				want = counts_due.pop_front();
				if (got !== want) begin
					$error("patch_count: expected %0d, actual %0d", want, got);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return counts_due.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [15:0]      cfg_data = '0;
	logic             start = 1'b0;
	logic             busy;
	logic [15:0]      leak_position = '0;
	logic             last_point = 1'b0;
	logic             done;
	logic [6:0]       patch_count;

	cover_tally board = new();
	int         cycles = 0;
	bit         gaps_on = 1'b1;
	int         lengths_used = 0;
	int         points_goal_done = 0;

	greedy_point_cover_counter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.leak_position(leak_position),
		.last_point   (last_point),
		.done         (done),
		.patch_count  (patch_count)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// results cannot be held off, so every strobe is checked on its own edge
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_count(patch_count);
	end

	// one point transfer, preceded by a random gap when gaps are on
	task automatic send_point(input pos_t pos, input logic last);
		int gap;
		gap = gaps_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		leak_position <= pos;
		last_point    <= last;
		do @(posedge clk); while (busy);
		board.note_point(pos, last);
	endtask

	// lets the block settle: every count in, then the sweep latency
	task automatic drain();
		start <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write, only issued with the block idle
	task automatic write_length(input logic [LEN_W-1:0] len);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.patch_len = len;
		lengths_used++;
	endtask

	// random set: mostly short sets in a window, now and then a full chain
	task automatic send_random_set();
		int   size;
		int   pick;
		int   width;
		pos_t anchor;
		pos_t pos;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			size = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 8);
		else if (pick < 3)
			size = $urandom_range(17, MAX_POINTS);
		else
			size = $urandom_range(1, 16);
		case ($urandom_range(0, 3))
			0: width = 16;
			1: width = 256;
			2: width = 4096;
			default: width = 65535;
		endcase
		anchor = pos_t'($urandom);
		for (int n = 0; n < size; n++) begin
			case ($urandom_range(0, 15))
				0: pos = '0;
				1: pos = '1;
				default: pos = anchor + pos_t'($urandom_range(0, width));
			endcase
			send_point(pos, n == size - 1);
		end
		points_goal_done += (size > MAX_POINTS) ? MAX_POINTS : size;
	endtask

	initial begin
		logic [LEN_W-1:0] len;
		int               phase;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: shortest patch, extremes of position, duplicates
		write_length(16'd1);
		send_point(16'd0, 1'b1);
		send_point(16'hffff, 1'b1);
		send_point(16'd5, 1'b0);
		send_point(16'd3, 1'b0);
		send_point(16'd5, 1'b0);
		send_point(16'd4, 1'b0);
		send_point(16'd9, 1'b1);
		send_point(16'hffff, 1'b0);
		send_point(16'd0, 1'b0);
		send_point(16'hfffe, 1'b1);

		// zero length: every uncovered point costs its own patch
		write_length(16'd0);
		send_point(16'd7, 1'b0);
		send_point(16'd7, 1'b0);
		send_point(16'd0, 1'b0);
		send_point(16'hffff, 1'b1);

		// longest patch reaches past the top of the position range
		write_length(16'hffff);
		send_point(16'd0, 1'b0);
		send_point(16'hffff, 1'b0);
		send_point(16'd30000, 1'b1);

		// random phases, each under its own length, extremes in rotation
		phase = 0;
		while (points_goal_done < POINT_GOAL) begin
			case (phase % 6)
				0: len = 16'd1;
				1: len = 16'd0;
				2: len = 16'hffff;
				3: len = LEN_W'($urandom_range(2, 8));
				4: len = LEN_W'($urandom_range(9, 400));
				default: len = LEN_W'($urandom);
			endcase
			write_length(len);
			// some phases run back to back with no gaps at all
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(6, 14))
				send_random_set();
			phase++;
		end

		drain();
		$display("covered %0d point transfers in %0d sets, %0d dropped on a full chain",
			board.points_taken, board.sets_closed, board.points_dropped);
		$display("checked %0d counts under %0d patch length settings",
			board.counts_seen, lengths_used);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- greedy_point_cover_counter.f -----
+incdir+rtl
rtl/gpc_pkg.sv
rtl/gpc_cell.sv
rtl/gpc_sweep.sv
rtl/greedy_point_cover_counter.sv
test/greedy_point_cover_counter_test.sv
